// ----- src/hcmi_pkg.sv -----
package hcmi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int HEAT_W    = FRAC_BITS + 2;
	localparam int VAL_W     = FRAC_BITS + 1;
	localparam logic [VAL_W-1:0] ONE_FX = VAL_W'(1) << FRAC_BITS;

	localparam int NUM_PAL = 18;
	localparam int MAX_ENT = 19;
	localparam int PAL_W   = 5;
	localparam int IDX_W   = 5;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_PALETTE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE   = 2'd1;

	typedef enum logic [2:0] {
		CURVE_LINEAR  = 3'd0,
		CURVE_SQUARE  = 3'd1,
		CURVE_CUBE    = 3'd2,
		CURVE_SQRT    = 3'd3,
		CURVE_CBRT    = 3'd4,
		CURVE_CLOSEST = 3'd5
	} curve_t;

	// (entries - 1) * 100 for each palette.
	localparam logic [10:0] PAL_SPAN [NUM_PAL] = '{
		11'd600, 11'd100, 11'd100, 11'd600, 11'd800, 11'd200, 11'd1800, 11'd400, 11'd400,
		11'd400, 11'd400, 11'd400, 11'd200, 11'd400, 11'd400, 11'd300, 11'd300, 11'd300
	};

	localparam logic [IDX_W-1:0] PAL_LAST [NUM_PAL] = '{
		5'd6, 5'd1, 5'd1, 5'd6, 5'd8, 5'd2, 5'd18, 5'd4, 5'd4,
		5'd4, 5'd4, 5'd4, 5'd2, 5'd4, 5'd4, 5'd3, 5'd3, 5'd3
	};

	localparam logic [23:0] PAL_ROM [NUM_PAL][MAX_ENT] = '{
		'{24'h000000, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'hFFFFFF,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'h000000, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'hFFFFFF, 24'hFF00FF, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'hFF0000, 24'hFF6600, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'h9F00FF,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'h000000, 24'hFF0000, 24'hFF6600, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF,
		  24'h9F00FF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0},
		'{24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'hFF0100, 24'hFF2000, 24'hFF3B02, 24'hFF5811, 24'hFF7326, 24'hFF8B40, 24'hFFA15E,
		  24'hFFB57D, 24'hFFC69E, 24'hFFD5BE, 24'hFFE2DD, 24'hFFEEFB, 24'hE7E2FF, 24'hD2D5FF,
		  24'hC2CCFF, 24'hB5C3FF, 24'hAABCFF, 24'hA1B6FF, 24'h99B0FF},
		'{24'h23BAD7, 24'h0C73DC, 24'h89D537, 24'hF8D68E, 24'hD3F0FF, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'h131C45, 24'h61858E, 24'hB1F0D2, 24'h619E79, 24'h003F34, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'h3B5998, 24'h8B9DC3, 24'hDFE3EE, 24'hF7F7F7, 24'hFFFFFF, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'h740000, 24'hAE0000, 24'hEEBA30, 24'hD3A625, 24'h000000, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'hCC1614, 24'hE5CEB0, 24'h2A334F, 24'h6B4423, 24'hAC8F57, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'hEE1515, 24'h222224, 24'hF0F0F0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'hFDCF58, 24'h757676, 24'hF27D0C, 24'h800909, 24'h000000, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'hB28200, 24'hFFC119, 24'hFFBA00, 24'h0029B2, 24'h003BFF, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'hE90084, 24'hFF0000, 24'h00E900, 24'hAAFF00, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'h0000FF, 24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
		'{24'hE90084, 24'hFF0000, 24'h00E900, 24'hAAFF00, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
		  24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0}
	};

endpackage

// ----- src/hcmi_if.sv -----
interface hcmi_in_if import hcmi_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [HEAT_W-1:0] heat_value;

	modport source (output valid, output heat_value, input ready);
	modport sink (input valid, input heat_value, output ready);
endinterface

interface hcmi_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface hcmi_cfg_if import hcmi_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/heat_colormap_interpolator_unit.sv -----
// Channel  Direction  Payload
// cfg      in         index (0 palette_select, 1 curve_mode), data
// heat     in         heat_value (signed, 16 fraction bits)
// color    out        red, green, blue
//
// One item can enter every cycle while color is not stalled. The depth is set by the
// square and cube root units, which resolve one result bit per stage over 17 stages.
// Reset clears the configuration registers and all stage valid bits.
// Each stage holds when the one after it is full and not moving, so bubbles
// are squeezed out and a stall on color loses or repeats nothing.
module heat_colormap_interpolator_unit import hcmi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	hcmi_cfg_if.sink   cfg,
	hcmi_in_if.sink    heat,
	hcmi_out_if.source color
);

	localparam int ROOT_STEPS = VAL_W;
	localparam int NSTG       = ROOT_STEPS + 6;
	localparam int ST_W       = ROOT_STEPS + 1;

	typedef struct packed {
		logic [VAL_W-1:0]  v;
		logic [35:0]       sq_rem;
		logic [VAL_W-1:0]  sq_y;
		logic [51:0]       cb_rem;
		logic [VAL_W-1:0]  cb_y;
		logic [33:0]       cb_q;
		logic [33:0]       sqr;
		logic [VAL_W-1:0]  cub;
		logic [2:0]        mode;
		logic [PAL_W-1:0]  pal;
		logic [10:0]       s;
		logic [IDX_W-1:0]  step;
		logic [6:0]        h;
		logic [23:0]       c0;
		logic [23:0]       c1;
		logic [14:0]       sum_r;
		logic [14:0]       sum_g;
		logic [14:0]       sum_b;
		logic [23:0]       col;
	} stage_t;

	logic [PAL_W-1:0] palette_q;
	logic [2:0]       curve_q;

	stage_t    pipe_s [NSTG];
	stage_t    nxt [NSTG];
	logic [NSTG-1:0] vld_s;
	logic [NSTG:0]   en;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= '0;
			curve_q   <= CURVE_LINEAR;
		end else if (cfg.valid) begin
			if (cfg.index == REG_PALETTE) begin
				palette_q <= cfg.data[PAL_W-1:0];
			end else if (cfg.index == REG_CURVE) begin
				curve_q <= cfg.data[2:0];
			end
		end
	end

	assign en[NSTG] = color.ready;
	genvar k;
	generate
		for (k = 0; k < NSTG; k++) begin : g_en
			assign en[k] = !vld_s[k] || en[k+1];
		end
	endgenerate
	assign heat.ready = en[0];

	// Stage 0: clamp to [0, 1].
	always_comb begin
		nxt[0] = '0;
		if (heat.heat_value[HEAT_W-1]) begin
			nxt[0].v = '0;
		end else if (heat.heat_value[VAL_W-1:0] > ONE_FX) begin
			nxt[0].v = ONE_FX;
		end else begin
			nxt[0].v = heat.heat_value[VAL_W-1:0];
		end
	end

	// Stages 1..17: one bit of the square root and one of the cube root per stage.
	generate
		for (k = 1; k <= ROOT_STEPS; k++) begin : g_root
			localparam int I = k - 1;
			always_comb begin
				logic [50:0] xc;
				logic [33:0] xs;
				logic [51:0] rc;
				logic [51:0] dc;
				logic [35:0] rs;
				logic [35:0] ds;
				nxt[k] = pipe_s[k-1];
				xc = {2'b0, pipe_s[k-1].v, 32'b0};
				xs = {1'b0, pipe_s[k-1].v, 16'b0};
				rc = {pipe_s[k-1].cb_rem[48:0], xc[50-3*I -: 3]};
				dc = {15'b0, pipe_s[k-1].cb_q, 3'b0} + {16'b0, pipe_s[k-1].cb_q, 2'b0}
					+ {33'b0, pipe_s[k-1].cb_y, 2'b0} + {34'b0, pipe_s[k-1].cb_y, 1'b0}
					+ 52'd1;
				if (rc >= dc) begin
					nxt[k].cb_rem = rc - dc;
					nxt[k].cb_y   = {pipe_s[k-1].cb_y[VAL_W-2:0], 1'b1};
					nxt[k].cb_q   = {pipe_s[k-1].cb_q[31:0], 2'b0}
						+ {15'b0, pipe_s[k-1].cb_y, 2'b0} + 34'd1;
				end else begin
					nxt[k].cb_rem = rc;
					nxt[k].cb_y   = {pipe_s[k-1].cb_y[VAL_W-2:0], 1'b0};
					nxt[k].cb_q   = {pipe_s[k-1].cb_q[31:0], 2'b0};
				end
				rs = {pipe_s[k-1].sq_rem[33:0], xs[33-2*I -: 2]};
				ds = {17'b0, pipe_s[k-1].sq_y, 2'b0} + 36'd1;
				if (rs >= ds) begin
					nxt[k].sq_rem = rs - ds;
					nxt[k].sq_y   = {pipe_s[k-1].sq_y[VAL_W-2:0], 1'b1};
				end else begin
					nxt[k].sq_rem = rs;
					nxt[k].sq_y   = {pipe_s[k-1].sq_y[VAL_W-2:0], 1'b0};
				end
				if (k == 1) begin
					nxt[k].sqr = 34'(pipe_s[k-1].v * pipe_s[k-1].v);
				end
				if (k == 2) begin
					nxt[k].cub = VAL_W'((51'(pipe_s[k-1].sqr) * 51'(pipe_s[k-1].v)) >> 32);
				end
			end
		end
	endgenerate

	// Curve select and scale to hundredths of a segment.
	always_comb begin
		logic [VAL_W-1:0] w;
		logic [27:0]      prod;
		logic [PAL_W-1:0] p;
		nxt[ROOT_STEPS+1] = pipe_s[ROOT_STEPS];
		p = (palette_q < PAL_W'(NUM_PAL)) ? palette_q : '0;
		unique case (curve_q)
			CURVE_SQUARE: w = pipe_s[ROOT_STEPS].sqr[32:16];
			CURVE_CUBE:   w = pipe_s[ROOT_STEPS].cub;
			CURVE_SQRT:   w = pipe_s[ROOT_STEPS].sq_y;
			CURVE_CBRT:   w = pipe_s[ROOT_STEPS].cb_y;
			default:      w = pipe_s[ROOT_STEPS].v;
		endcase
		prod = 28'(w) * 28'(PAL_SPAN[p]);
		nxt[ROOT_STEPS+1].pal  = p;
		nxt[ROOT_STEPS+1].mode = curve_q;
		nxt[ROOT_STEPS+1].s    = prod[26:16];
	end

	// Segment index and hundredths; s/100 by reciprocal, exact for s up to 1800.
	always_comb begin
		logic [23:0] t;
		logic [10:0] rem;
		nxt[ROOT_STEPS+2] = pipe_s[ROOT_STEPS+1];
		t = 24'(pipe_s[ROOT_STEPS+1].s) * 24'd5243;
		nxt[ROOT_STEPS+2].step = t[23:19];
		rem = pipe_s[ROOT_STEPS+1].s - 11'(t[23:19]) * 11'd100;
		nxt[ROOT_STEPS+2].h = rem[6:0];
	end

	// Palette lookup; at or past the last segment both ends are the last entry.
	always_comb begin
		logic [IDX_W-1:0] last;
		logic [IDX_W-1:0] st;
		logic [PAL_W-1:0] p;
		nxt[ROOT_STEPS+3] = pipe_s[ROOT_STEPS+2];
		p = pipe_s[ROOT_STEPS+2].pal;
		st = pipe_s[ROOT_STEPS+2].step;
		last = PAL_LAST[p];
		if (st >= last) begin
			nxt[ROOT_STEPS+3].c0 = PAL_ROM[p][last];
			nxt[ROOT_STEPS+3].c1 = PAL_ROM[p][last];
			nxt[ROOT_STEPS+3].h  = '0;
		end else begin
			nxt[ROOT_STEPS+3].c0 = PAL_ROM[p][st];
			nxt[ROOT_STEPS+3].c1 = PAL_ROM[p][st + IDX_W'(1)];
		end
	end

	// Weighted sums per channel, and the nearest entry for closest match.
	always_comb begin
		logic [6:0] h;
		logic [6:0] hn;
		stage_t     pr;
		pr = pipe_s[ROOT_STEPS+3];
		nxt[ROOT_STEPS+4] = pr;
		h  = pr.h;
		hn = 7'd100 - h;
		nxt[ROOT_STEPS+4].sum_r = 15'(pr.c0[23:16]) * 15'(hn) + 15'(pr.c1[23:16]) * 15'(h);
		nxt[ROOT_STEPS+4].sum_g = 15'(pr.c0[15:8]) * 15'(hn) + 15'(pr.c1[15:8]) * 15'(h);
		nxt[ROOT_STEPS+4].sum_b = 15'(pr.c0[7:0]) * 15'(hn) + 15'(pr.c1[7:0]) * 15'(h);
		nxt[ROOT_STEPS+4].col   = (h < 7'd50) ? pr.c0 : pr.c1;
	end

	// Divide sums by 100 by reciprocal; exact for sums up to 25500. Closest match keeps the nearest entry.
	always_comb begin
		logic [27:0] tr;
		logic [27:0] tg;
		logic [27:0] tb;
		stage_t      pr;
		pr = pipe_s[ROOT_STEPS+4];
		nxt[ROOT_STEPS+5] = pr;
		tr = 28'(pr.sum_r) * 28'd5243;
		tg = 28'(pr.sum_g) * 28'd5243;
		tb = 28'(pr.sum_b) * 28'd5243;
		if (pr.mode != CURVE_CLOSEST) begin
			nxt[ROOT_STEPS+5].col = {tr[26:19], tg[26:19], tb[26:19]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 0; i < NSTG; i++) begin
				if (en[i]) begin
					vld_s[i] <= (i == 0) ? heat.valid : vld_s[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NSTG; i++) begin
			if (en[i]) begin
				pipe_s[i] <= nxt[i];
			end
		end
	end

	assign color.valid = vld_s[NSTG-1];
	assign color.red   = pipe_s[NSTG-1].col[23:16];
	assign color.green = pipe_s[NSTG-1].col[15:8];
	assign color.blue  = pipe_s[NSTG-1].col[7:0];

endmodule
